// ===== sv/nnds_pkg.sv =====
// Shared types, constants and helpers for the nearest-neighbor DDA scaler.
`default_nettype none
package nnds_pkg;

  localparam int STORE_DEPTH_DEF = 65536;
  localparam int MAX_DIM         = 1024;
  localparam int DIM_W           = 11;
  localparam int PIX_W           = 8;
  localparam int SRC_ADDR_W      = 16;
  localparam int DST_ADDR_W      = 16;
  localparam int DIV_W           = 12;
  localparam int ERR_W           = 13;
  localparam int NUM_REGS        = 6;
  localparam int REG_IDX_W       = 3;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_EMIT    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_W      = 3'd0,
    REG_SRC_H      = 3'd1,
    REG_DST_W      = 3'd2,
    REG_DST_H      = 3'd3,
    REG_SRC_STRIDE = 3'd4,
    REG_DST_STRIDE = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_LAUNCH_X,
    SU_WAIT_X,
    SU_LAUNCH_Y,
    SU_WAIT_Y,
    SU_MUL,
    SU_DONE
  } setup_state_t;

  typedef struct packed {
    logic [DIM_W-1:0] whole_x;
    logic [DIV_W-1:0] rem_x;
    logic [DIV_W-1:0] den_x;
    logic [DIV_W-1:0] rem_y;
    logic [DIV_W-1:0] den_y;
    logic [DIM_W-1:0] src_stride;
    logic [DIM_W-1:0] dst_stride;
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
  } step_terms_t;

  typedef struct packed {
    logic busy;
    logic done;
  } setup_stat_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W:0] lim;
    lim = (DIM_W+1)'(MAX_DIM);
    if ({1'b0, v} > lim) begin
      return lim[DIM_W-1:0];
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/nnds_if.sv =====
// Valid/ready channel interfaces for source items and scaled pixels.
`default_nettype none
interface nnds_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [nnds_pkg::SRC_ADDR_W-1:0] source_address;
  logic [nnds_pkg::PIX_W-1:0]      source_value;

  modport source (output valid, kind, source_address, source_value, input ready);
  modport sink   (input valid, kind, source_address, source_value, output ready);
endinterface

interface nnds_out_if;
  logic                            valid;
  logic                            ready;
  logic [nnds_pkg::PIX_W-1:0]      pixel;
  logic [nnds_pkg::DST_ADDR_W-1:0] dest_address;
  logic                            last;

  modport source (output valid, pixel, dest_address, last, input ready);
  modport sink   (input valid, pixel, dest_address, last, output ready);
endinterface
`default_nettype wire

// ===== sv/nnds_frame_store.sv =====
// Frame store: one write port, one registered read port.
`default_nettype none
module nnds_frame_store #(
  parameter int DEPTH  = nnds_pkg::STORE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(nnds_pkg::STORE_DEPTH_DEF)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [nnds_pkg::PIX_W-1:0] wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [nnds_pkg::PIX_W-1:0] rdata
);
  import nnds_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/nnds_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module nnds_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nnds_pkg::DIV_W-1:0] dividend,
  input  logic [nnds_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [nnds_pkg::DIV_W-1:0] quotient,
  output logic [nnds_pkg::DIV_W-1:0] remainder
);
  import nnds_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dvs_r;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIV_W);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r && (cnt_r != '0)) begin
      if (!trial[DIV_W]) begin
        rem_r <= trial[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done      = busy_r && (cnt_r == '0);
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ===== sv/nnds_setup.sv =====
// Frame setup sequencer: whole and remainder steps for both axes.
`default_nettype none
module nnds_setup #(
  parameter int ADDR_W = $clog2(nnds_pkg::STORE_DEPTH_DEF)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nnds_pkg::DIM_W-1:0] src_w,
  input  logic [nnds_pkg::DIM_W-1:0] src_h,
  input  logic [nnds_pkg::DIM_W-1:0] dst_w,
  input  logic [nnds_pkg::DIM_W-1:0] dst_h,
  input  logic [nnds_pkg::DIM_W-1:0] src_stride,
  input  logic [nnds_pkg::DIM_W-1:0] dst_stride,
  output nnds_pkg::step_terms_t      terms,
  output logic [ADDR_W-1:0]          whole_y,
  output nnds_pkg::setup_stat_t      stat
);
  import nnds_pkg::*;

  setup_state_t     state_r, state_nxt;
  step_terms_t      terms_r;
  logic [DIV_W-1:0] a_x_r, a_y_r;
  logic [DIM_W-1:0] quo_y_r;
  logic [ADDR_W-1:0] whole_y_r;
  logic [2*DIM_W-1:0] prod;

  logic             div_start, div_sel_y, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q, div_rem;

  assign div_a = div_sel_y ? a_y_r : a_x_r;
  assign div_b = div_sel_y ? terms_r.den_y : terms_r.den_x;

  nnds_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SU_IDLE:     if (start) state_nxt = SU_LAUNCH_X;
      SU_LAUNCH_X: state_nxt = SU_WAIT_X;
      SU_WAIT_X:   if (div_done) state_nxt = SU_LAUNCH_Y;
      SU_LAUNCH_Y: state_nxt = SU_WAIT_Y;
      SU_WAIT_Y:   if (div_done) state_nxt = SU_MUL;
      SU_MUL:      state_nxt = SU_DONE;
      SU_DONE:     state_nxt = SU_IDLE;
      default:     state_nxt = SU_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_sel_y = 1'b0;
    stat.busy = 1'b1;
    stat.done = 1'b0;
    case (state_r)
      SU_IDLE:     stat.busy = 1'b0;
      SU_LAUNCH_X: div_start = 1'b1;
      SU_WAIT_X:   div_sel_y = 1'b0;
      SU_LAUNCH_Y: begin
        div_start = 1'b1;
        div_sel_y = 1'b1;
      end
      SU_WAIT_Y:   div_sel_y = 1'b1;
      SU_MUL:      div_sel_y = 1'b1;
      SU_DONE:     stat.done = 1'b1;
      default:     stat.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign prod = quo_y_r * terms_r.src_stride;

  always_ff @(posedge clk) begin
    if ((state_r == SU_IDLE) && start) begin
      a_x_r              <= {src_w, 1'b0};
      a_y_r              <= {src_h, 1'b0};
      terms_r.den_x      <= {dst_w, 1'b0};
      terms_r.den_y      <= {dst_h, 1'b0};
      terms_r.src_stride <= src_stride;
      terms_r.dst_stride <= dst_stride;
      terms_r.dst_w      <= dst_w;
      terms_r.dst_h      <= dst_h;
    end
    if ((state_r == SU_WAIT_X) && div_done) begin
      if (terms_r.den_x < a_x_r) begin
        terms_r.whole_x <= div_q[DIM_W-1:0];
        terms_r.rem_x   <= div_rem;
      end else begin
        terms_r.whole_x <= '0;
        terms_r.rem_x   <= a_x_r;
      end
    end
    if ((state_r == SU_WAIT_Y) && div_done) begin
      if (terms_r.den_y < a_y_r) begin
        quo_y_r       <= div_q[DIM_W-1:0];
        terms_r.rem_y <= div_rem;
      end else begin
        quo_y_r       <= '0;
        terms_r.rem_y <= a_y_r;
      end
    end
    if (state_r == SU_MUL) begin
      whole_y_r <= ADDR_W'(prod);
    end
  end

  assign terms   = terms_r;
  assign whole_y = whole_y_r;

endmodule
`default_nettype wire

// ===== sv/nearest_neighbor_dda_scaler_unit.sv =====
// Top level: config registers, raster walk, frame store and result registers.
// Write and emit items: one transfer per cycle while setup is idle and the output is not
// stalled; an emit result passes through the frame store read, then the output register.
// Restart: the input stalls while the serial divider runs twelve steps for each axis,
// followed by one stride multiply; no stall when a size is zero.
// Reset clears control state and sets registers to their defaults; frame store
// contents stay undefined until written.
`default_nettype none
module nearest_neighbor_dda_scaler_unit #(
  parameter int STORE_DEPTH = nnds_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  nnds_in_if.sink                        in_ch,
  nnds_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [nnds_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [nnds_pkg::DIM_W-1:0]     cfg_data
);
  import nnds_pkg::*;

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  logic [DIM_W-1:0] cfg_r [NUM_REGS];

  step_terms_t       terms;
  logic [ADDR_W-1:0] whole_y;
  setup_stat_t       setup_stat;

  logic                    active_r, active_nxt;
  logic [ADDR_W-1:0]       read_ptr_r, read_ptr_nxt;
  logic [ADDR_W-1:0]       row_base_r, row_base_nxt;
  logic signed [ERR_W-1:0] col_err_r, col_err_nxt;
  logic signed [ERR_W-1:0] row_err_r, row_err_nxt;
  logic [DIM_W-1:0]        col_cnt_r, col_cnt_nxt;
  logic [DIM_W-1:0]        row_cnt_r, row_cnt_nxt;
  logic [DST_ADDR_W-1:0]   dest_row_r, dest_row_nxt;

  logic                    s1_valid_r;
  logic [DST_ADDR_W-1:0]   s1_addr_r;
  logic                    s1_last_r;
  logic                    out_valid_r;
  logic [PIX_W-1:0]        out_pixel_r;
  logic [DST_ADDR_W-1:0]   out_addr_r;
  logic                    out_last_r;

  logic             in_ready, accept, is_write, is_emit, is_restart, sizes_ok;
  logic             out_move, last_now;
  logic [PIX_W-1:0] rd_data;

  logic [ADDR_W-1:0]       ptr_step, rb_step;
  logic signed [ERR_W-1:0] ce_add, re_add;
  logic [DIM_W-1:0]        col_inc, row_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_SRC_W]      <= '0;
      cfg_r[REG_SRC_H]      <= '0;
      cfg_r[REG_DST_W]      <= '0;
      cfg_r[REG_DST_H]      <= '0;
      cfg_r[REG_SRC_STRIDE] <= DIM_W'(1);
      cfg_r[REG_DST_STRIDE] <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_W:      cfg_r[REG_SRC_W]      <= sat_dim(cfg_data);
        REG_SRC_H:      cfg_r[REG_SRC_H]      <= sat_dim(cfg_data);
        REG_DST_W:      cfg_r[REG_DST_W]      <= sat_dim(cfg_data);
        REG_DST_H:      cfg_r[REG_DST_H]      <= sat_dim(cfg_data);
        REG_SRC_STRIDE: cfg_r[REG_SRC_STRIDE] <= sat_dim(cfg_data);
        REG_DST_STRIDE: cfg_r[REG_DST_STRIDE] <= sat_dim(cfg_data);
        default: ;
      endcase
    end
  end

  assign out_move   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready   = !setup_stat.busy && (!s1_valid_r || !out_valid_r || out_ch.ready);
  assign accept     = in_ch.valid && in_ready;
  assign is_write   = accept && (in_ch.kind == KIND_WRITE);
  assign is_emit    = accept && (in_ch.kind == KIND_EMIT) && active_r;
  assign is_restart = accept && (in_ch.kind == KIND_RESTART);
  assign sizes_ok   = (cfg_r[REG_SRC_W] != '0) && (cfg_r[REG_SRC_H] != '0) &&
                      (cfg_r[REG_DST_W] != '0) && (cfg_r[REG_DST_H] != '0);

  assign in_ch.ready = in_ready;

  nnds_setup #(
    .ADDR_W (ADDR_W)
  ) u_setup (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (is_restart && sizes_ok),
    .src_w      (cfg_r[REG_SRC_W]),
    .src_h      (cfg_r[REG_SRC_H]),
    .dst_w      (cfg_r[REG_DST_W]),
    .dst_h      (cfg_r[REG_DST_H]),
    .src_stride (cfg_r[REG_SRC_STRIDE]),
    .dst_stride (cfg_r[REG_DST_STRIDE]),
    .terms      (terms),
    .whole_y    (whole_y),
    .stat       (setup_stat)
  );

  nnds_frame_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (is_write),
    .waddr (ADDR_W'(in_ch.source_address)),
    .wdata (in_ch.source_value),
    .re    (is_emit),
    .raddr (read_ptr_r),
    .rdata (rd_data)
  );

  always_comb begin
    active_nxt   = active_r;
    read_ptr_nxt = read_ptr_r;
    row_base_nxt = row_base_r;
    col_err_nxt  = col_err_r;
    row_err_nxt  = row_err_r;
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    dest_row_nxt = dest_row_r;
    last_now     = 1'b0;

    ptr_step = read_ptr_r + ADDR_W'(terms.whole_x);
    ce_add   = col_err_r + $signed({1'b0, terms.rem_x});
    rb_step  = row_base_r + whole_y;
    re_add   = row_err_r + $signed({1'b0, terms.rem_y});
    col_inc  = col_cnt_r + 1'b1;
    row_inc  = row_cnt_r + 1'b1;

    if (is_restart) begin
      active_nxt   = 1'b0;
      read_ptr_nxt = '0;
      row_base_nxt = '0;
      col_err_nxt  = '0;
      row_err_nxt  = '0;
      col_cnt_nxt  = '0;
      row_cnt_nxt  = '0;
      dest_row_nxt = '0;
    end else if (setup_stat.done) begin
      active_nxt  = 1'b1;
      col_err_nxt = -$signed({1'b0, terms.den_x});
      row_err_nxt = -$signed({1'b0, terms.den_y});
    end else if (is_emit) begin
      if (ce_add > 0) begin
        read_ptr_nxt = ptr_step + 1'b1;
        col_err_nxt  = ce_add - $signed({1'b0, terms.den_x});
      end else begin
        read_ptr_nxt = ptr_step;
        col_err_nxt  = ce_add;
      end
      col_cnt_nxt = col_inc;
      if (col_inc >= terms.dst_w) begin
        col_cnt_nxt  = '0;
        row_cnt_nxt  = row_inc;
        dest_row_nxt = dest_row_r + DST_ADDR_W'(terms.dst_stride);
        if (re_add > 0) begin
          row_base_nxt = rb_step + ADDR_W'(terms.src_stride);
          row_err_nxt  = re_add - $signed({1'b0, terms.den_y});
        end else begin
          row_base_nxt = rb_step;
          row_err_nxt  = re_add;
        end
        read_ptr_nxt = row_base_nxt;
        col_err_nxt  = -$signed({1'b0, terms.den_x});
        if (row_inc >= terms.dst_h) begin
          active_nxt = 1'b0;
          last_now   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      read_ptr_r <= '0;
      row_base_r <= '0;
      col_err_r  <= '0;
      row_err_r  <= '0;
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      dest_row_r <= '0;
    end else begin
      active_r   <= active_nxt;
      read_ptr_r <= read_ptr_nxt;
      row_base_r <= row_base_nxt;
      col_err_r  <= col_err_nxt;
      row_err_r  <= row_err_nxt;
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      dest_row_r <= dest_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= is_emit || (s1_valid_r && !out_move);
      if (out_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_emit) begin
      s1_addr_r <= dest_row_r + DST_ADDR_W'(col_cnt_r);
      s1_last_r <= last_now;
    end
    if (out_move) begin
      out_pixel_r <= rd_data;
      out_addr_r  <= s1_addr_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel        = out_pixel_r;
  assign out_ch.dest_address = out_addr_r;
  assign out_ch.last         = out_last_r;

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    setup_stat.busy |-> !in_ready)
    else $error("input accepted during frame setup");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (is_emit && last_now) |=> !active_r)
    else $error("frame still active after last pixel");

  a_no_active_setup: assert property (@(posedge clk) disable iff (!rst_n)
    !(active_r && setup_stat.busy))
    else $error("frame active while setup runs");

  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |=> s1_valid_r)
    else $error("pending read lost under stall");

endmodule
`default_nettype wire
